@@ design/btfl_pkg.sv @@
// ----------------------------------------------------------------------------
// btfl_pkg
// Shared types and constants for the boundary-tag free-list allocator.
// ----------------------------------------------------------------------------
package btfl_pkg;

    localparam int ARENA_DEPTH     = 4096;
    localparam int IDX_W           = $clog2(ARENA_DEPTH);
    localparam int AW_W            = IDX_W + 1;
    localparam int ADDR_W          = 17;
    localparam int WORD_W          = 16;
    localparam int MIN_BLOCK_WORDS = 4;
    localparam int FREE_MIN        = 4;

    localparam logic [WORD_W-1:0] NIL = 16'hFFFF;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_NOFIT = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] wdata;
    } mem_req_t;

endpackage

@@ design/boundary_tag_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// boundary_tag_free_list_allocator
// First-fit allocator over a word arena with boundary tags and an explicit
// doubly linked free list, run by a sequencer over one memory port.
// ----------------------------------------------------------------------------
// One word in flight at a time; the list walk over the single arena port
//   sets the rate.
// Reset and arena_words write: clear pass over all arena_words words, then
//   the S_INIT0 to S_INIT3 writes; no input taken meanwhile.
module boundary_tag_free_list_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // opcode[0], request_words[13:1], block_addr[25:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // status[1:0], grant_addr[13:2]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data
);

    localparam int AW = btfl_pkg::ADDR_W;
    localparam int WW = btfl_pkg::WORD_W;
    localparam int CW = btfl_pkg::AW_W;

    typedef enum logic [5:0] {
        S_CLR, S_INIT0, S_INIT1, S_INIT2, S_INIT3, S_IDLE,
        S_SCHK, S_SHDR, S_SNXT, S_A_INS, S_A_TAG, S_A_RM,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_FD, S_FN2, S_FN3, S_FB2,
        S_TAG_H, S_TAG_F, S_INS1, S_INS2, S_INS3,
        S_RMA, S_RMB, S_RMC, S_RMD, S_FIN
    } state_t;

    state_t              state_reg, ret_reg;
    logic [CW-1:0]       aw_reg, clr_reg;
    logic [12:0]         head_reg;
    logic                hv_reg;
    logic [12:0]         n_reg, steps_reg;
    logic [11:0]         addr_reg;
    logic [13:0]         req_reg;
    logic [AW-1:0]       b_reg, nb_reg, pstart_reg, tb_reg, lb_reg;
    logic [WW-1:0]       t_reg, bs_reg, psz_reg, nsz_reg, tsz_reg, nx_reg, pv_reg;
    logic                ttag_reg, pf_reg, nf_reg;
    logic [1:0]          st_reg, ost_reg;
    logic [11:0]         gr_reg, ogr_reg;
    logic                mv_reg;
    btfl_pkg::mem_req_t  mreq;
    logic [WW-1:0]       rd_data;
    logic [CW-1:0]       cfg_sat;
    logic [CW-1:0]       limit;
    logic [WW-1:0]       hdr_sz, bs_c;
    logic [AW-1:0]       aw_x;
    logic                head_is_lb;

    btfl_arena u_arena
    (
        .clk         (clk),
        .arena_words (aw_reg),
        .req         (mreq),
        .rd_data     (rd_data)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = {2'b00, ogr_reg, ost_reg};

    assign aw_x       = AW'(aw_reg);
    assign limit      = CW'(aw_reg >> 2) + CW'(2);
    assign hdr_sz     = {1'b0, rd_data[WW-1:1]};
    assign bs_c       = (AW'(hdr_sz) > aw_x - b_reg) ? WW'(aw_x - b_reg) : hdr_sz;
    assign head_is_lb = hv_reg && (AW'(head_reg) == lb_reg);

    always_comb
    begin
        if (cfg_data < 13'd8)
        begin
            cfg_sat = CW'(8);
        end
        else if (cfg_data > 13'(btfl_pkg::ARENA_DEPTH))
        begin
            cfg_sat = CW'(btfl_pkg::ARENA_DEPTH);
        end
        else
        begin
            cfg_sat = cfg_data;
        end
    end

    always_comb
    begin
        mreq = '0;
        unique case (state_reg)
            S_CLR:
            begin
                mreq.we   = 1'b1;
                mreq.addr = AW'(clr_reg);
            end
            S_INIT0:
            begin
                mreq.we    = 1'b1;
                mreq.wdata = {2'b00, aw_reg, 1'b0};
            end
            S_INIT1:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = aw_x - AW'(1);
                mreq.wdata = {2'b00, aw_reg, 1'b0};
            end
            S_INIT2:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = AW'(1);
                mreq.wdata = btfl_pkg::NIL;
            end
            S_INIT3:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = AW'(2);
                mreq.wdata = btfl_pkg::NIL;
            end
            S_SCHK:
            begin
                mreq.re   = 1'b1;
                mreq.addr = b_reg;
            end
            S_SHDR:
            begin
                mreq.re   = 1'b1;
                mreq.addr = b_reg + AW'(1);
            end
            S_F0:
            begin
                mreq.re   = 1'b1;
                mreq.addr = AW'(addr_reg) - AW'(1);
            end
            S_F1:
            begin
                mreq.re   = 1'b1;
                mreq.addr = b_reg + AW'(hdr_sz) - AW'(1);
            end
            S_F2:
            begin
                mreq.re   = 1'b1;
                mreq.addr = b_reg - AW'(1);
            end
            S_F4:
            begin
                mreq.re   = 1'b1;
                mreq.addr = nb_reg;
            end
            S_TAG_H:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = tb_reg;
                mreq.wdata = {tsz_reg[WW-2:0], ttag_reg};
            end
            S_TAG_F:
            begin
                mreq.we    = (tsz_reg != '0);
                mreq.addr  = tb_reg + AW'(tsz_reg) - AW'(1);
                mreq.wdata = {tsz_reg[WW-2:0], ttag_reg};
            end
            S_INS1:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = lb_reg + AW'(1);
                mreq.wdata = hv_reg ? WW'(head_reg) : btfl_pkg::NIL;
            end
            S_INS2:
            begin
                mreq.we    = 1'b1;
                mreq.addr  = lb_reg + AW'(2);
                mreq.wdata = btfl_pkg::NIL;
            end
            S_INS3:
            begin
                mreq.we    = hv_reg;
                mreq.addr  = AW'(head_reg) + AW'(2);
                mreq.wdata = lb_reg[WW-1:0];
            end
            S_RMA:
            begin
                mreq.re   = 1'b1;
                mreq.addr = lb_reg + AW'(1);
            end
            S_RMB:
            begin
                mreq.re   = 1'b1;
                mreq.addr = lb_reg + AW'(2);
            end
            S_RMC:
            begin
                mreq.we    = (nx_reg != btfl_pkg::NIL);
                mreq.addr  = AW'(nx_reg) + AW'(2);
                mreq.wdata = rd_data;
            end
            S_RMD:
            begin
                mreq.we    = !head_is_lb && (pv_reg != btfl_pkg::NIL);
                mreq.addr  = AW'(pv_reg) + AW'(1);
                mreq.wdata = nx_reg;
            end
            default:
            begin
                mreq = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            ret_reg   <= S_FIN;
            aw_reg    <= CW'(btfl_pkg::ARENA_DEPTH);
            clr_reg   <= '0;
            head_reg  <= '0;
            hv_reg    <= 1'b1;
            mv_reg    <= 1'b0;
            ost_reg   <= '0;
            ogr_reg   <= '0;
        end
        else
        begin
            if (mv_reg && m_tready)
            begin
                mv_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + CW'(1);
                    if (clr_reg == aw_reg - CW'(1))
                    begin
                        state_reg <= S_INIT0;
                    end
                end
                S_INIT0: state_reg <= S_INIT1;
                S_INIT1: state_reg <= S_INIT2;
                S_INIT2: state_reg <= S_INIT3;
                S_INIT3:
                begin
                    head_reg  <= '0;
                    hv_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        n_reg     <= s_tdata[13:1];
                        addr_reg  <= s_tdata[25:14];
                        st_reg    <= btfl_pkg::ST_OK;
                        gr_reg    <= '0;
                        b_reg     <= AW'(head_reg);
                        steps_reg <= '0;
                        req_reg   <= (s_tdata[13:1] < 13'(btfl_pkg::FREE_MIN - 2))
                                     ? 14'(btfl_pkg::FREE_MIN)
                                     : 14'(s_tdata[13:1]) + 14'd2;
                        if (s_tdata[0] == btfl_pkg::OP_FREE)
                        begin
                            state_reg <= S_F0;
                        end
                        else if (s_tdata[13:1] == '0)
                        begin
                            st_reg    <= btfl_pkg::ST_ZERO;
                            state_reg <= S_FIN;
                        end
                        else if (!hv_reg)
                        begin
                            st_reg    <= btfl_pkg::ST_NOFIT;
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            state_reg <= S_SCHK;
                        end
                    end
                end
                S_SCHK:
                begin
                    if (steps_reg >= limit || b_reg >= aw_x)
                    begin
                        st_reg    <= btfl_pkg::ST_NOFIT;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_SHDR;
                    end
                end
                S_SHDR:
                begin
                    if (hdr_sz >= WW'(req_reg))
                    begin
                        if (bs_c - WW'(req_reg) > WW'(btfl_pkg::MIN_BLOCK_WORDS) &&
                            bs_c - WW'(req_reg) >= WW'(btfl_pkg::FREE_MIN))
                        begin
                            tb_reg    <= b_reg + AW'(req_reg);
                            tsz_reg   <= bs_c - WW'(req_reg);
                            ttag_reg  <= 1'b0;
                            ret_reg   <= S_A_INS;
                            state_reg <= S_TAG_H;
                        end
                        else
                        begin
                            req_reg   <= bs_c[13:0];
                            state_reg <= S_A_TAG;
                        end
                    end
                    else
                    begin
                        state_reg <= S_SNXT;
                    end
                end
                S_SNXT:
                begin
                    b_reg     <= AW'(rd_data);
                    steps_reg <= steps_reg + 13'd1;
                    if (rd_data == btfl_pkg::NIL)
                    begin
                        st_reg    <= btfl_pkg::ST_NOFIT;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_SCHK;
                    end
                end
                S_A_INS:
                begin
                    lb_reg    <= b_reg + AW'(req_reg);
                    ret_reg   <= S_A_TAG;
                    state_reg <= S_INS1;
                end
                S_A_TAG:
                begin
                    tb_reg    <= b_reg;
                    tsz_reg   <= WW'(req_reg);
                    ttag_reg  <= 1'b1;
                    ret_reg   <= S_A_RM;
                    state_reg <= S_TAG_H;
                end
                S_A_RM:
                begin
                    lb_reg    <= b_reg;
                    gr_reg    <= b_reg[11:0] + 12'd1;
                    ret_reg   <= S_FIN;
                    state_reg <= S_RMA;
                end
                S_F0:
                begin
                    b_reg <= AW'(addr_reg) - AW'(1);
                    if (addr_reg == '0 || CW'(addr_reg) >= aw_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_F1;
                    end
                end
                S_F1:
                begin
                    t_reg  <= rd_data;
                    bs_reg <= hdr_sz;
                    nb_reg <= b_reg + AW'(hdr_sz);
                    if (!rd_data[0] || hdr_sz < WW'(btfl_pkg::FREE_MIN) ||
                        AW'(hdr_sz) > aw_x - b_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        state_reg <= S_F2;
                    end
                end
                S_F2:
                begin
                    pf_reg <= 1'b0;
                    if (rd_data != t_reg)
                    begin
                        state_reg <= S_FIN;
                    end
                    else if (b_reg != '0)
                    begin
                        state_reg <= S_F3;
                    end
                    else
                    begin
                        state_reg <= S_F4;
                    end
                end
                S_F3:
                begin
                    psz_reg    <= hdr_sz;
                    pstart_reg <= b_reg - AW'(hdr_sz);
                    pf_reg     <= !rd_data[0] && hdr_sz >= WW'(btfl_pkg::FREE_MIN) &&
                                  AW'(hdr_sz) <= b_reg;
                    state_reg  <= S_F4;
                end
                S_F4:
                begin
                    nf_reg <= 1'b0;
                    if (nb_reg < aw_x)
                    begin
                        state_reg <= S_F5;
                    end
                    else
                    begin
                        state_reg <= S_FD;
                    end
                end
                S_F5:
                begin
                    nsz_reg   <= hdr_sz;
                    nf_reg    <= !rd_data[0] && hdr_sz >= WW'(btfl_pkg::FREE_MIN) &&
                                 AW'(hdr_sz) <= aw_x - nb_reg;
                    state_reg <= S_FD;
                end
                S_FD:
                begin
                    ttag_reg <= 1'b0;
                    priority if (!pf_reg && !nf_reg)
                    begin
                        tb_reg    <= b_reg;
                        tsz_reg   <= bs_reg;
                        ret_reg   <= S_FN3;
                        state_reg <= S_TAG_H;
                    end
                    else if (!pf_reg)
                    begin
                        lb_reg    <= nb_reg;
                        ret_reg   <= S_FN2;
                        state_reg <= S_RMA;
                    end
                    else if (!nf_reg)
                    begin
                        tb_reg    <= pstart_reg;
                        tsz_reg   <= psz_reg + bs_reg;
                        ret_reg   <= S_FIN;
                        state_reg <= S_TAG_H;
                    end
                    else
                    begin
                        lb_reg    <= nb_reg;
                        tsz_reg   <= psz_reg + bs_reg;
                        ret_reg   <= S_FB2;
                        state_reg <= S_RMA;
                    end
                end
                S_FN2:
                begin
                    tb_reg    <= b_reg;
                    tsz_reg   <= bs_reg + nsz_reg;
                    ret_reg   <= S_FN3;
                    state_reg <= S_TAG_H;
                end
                S_FN3:
                begin
                    lb_reg    <= b_reg;
                    ret_reg   <= S_FIN;
                    state_reg <= S_INS1;
                end
                S_FB2:
                begin
                    tb_reg    <= pstart_reg;
                    tsz_reg   <= tsz_reg + nsz_reg;
                    ret_reg   <= S_FIN;
                    state_reg <= S_TAG_H;
                end
                S_TAG_H: state_reg <= S_TAG_F;
                S_TAG_F: state_reg <= ret_reg;
                S_INS1:  state_reg <= S_INS2;
                S_INS2:  state_reg <= S_INS3;
                S_INS3:
                begin
                    head_reg  <= lb_reg[12:0];
                    hv_reg    <= 1'b1;
                    state_reg <= ret_reg;
                end
                S_RMA: state_reg <= S_RMB;
                S_RMB:
                begin
                    nx_reg    <= rd_data;
                    state_reg <= S_RMC;
                end
                S_RMC:
                begin
                    pv_reg    <= rd_data;
                    state_reg <= S_RMD;
                end
                S_RMD:
                begin
                    if (head_is_lb)
                    begin
                        if (nx_reg == btfl_pkg::NIL)
                        begin
                            hv_reg <= 1'b0;
                        end
                        else
                        begin
                            head_reg <= nx_reg[12:0];
                        end
                    end
                    state_reg <= ret_reg;
                end
                S_FIN:
                begin
                    if (!mv_reg || m_tready)
                    begin
                        mv_reg    <= 1'b1;
                        ost_reg   <= st_reg;
                        ogr_reg   <= gr_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (cfg_valid)
            begin
                aw_reg    <= cfg_sat;
                clr_reg   <= '0;
                state_reg <= S_CLR;
            end
        end
    end

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != 2'd3))
        else $error("status code out of range");

    a_grant_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[13:2] != '0) |-> (m_tdata[1:0] == btfl_pkg::ST_OK))
        else $error("grant address with failure status");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |=> !s_tready)
        else $error("input taken right after arena reinit");

    a_arena_range: assert property (@(posedge clk) disable iff (!rst_n)
        (aw_reg >= CW'(8)) && (aw_reg <= CW'(btfl_pkg::ARENA_DEPTH)))
        else $error("arena size outside saturation range");

endmodule

@@ design/btfl_arena.sv @@
// ----------------------------------------------------------------------------
// btfl_arena
// Arena word memory with bounds check; out-of-range reads return zero and
// out-of-range writes are dropped. Registered read.
// ----------------------------------------------------------------------------
module btfl_arena
(
    input  logic                      clk,
    input  logic [btfl_pkg::AW_W-1:0] arena_words,
    input  btfl_pkg::mem_req_t        req,
    output logic [btfl_pkg::WORD_W-1:0] rd_data
);

    logic [btfl_pkg::WORD_W-1:0] mem [btfl_pkg::ARENA_DEPTH];
    logic [btfl_pkg::WORD_W-1:0] raw_reg;
    logic                        ok_reg;
    logic                        in_range;

    assign in_range = req.addr < btfl_pkg::ADDR_W'(arena_words);
    assign rd_data  = ok_reg ? raw_reg : '0;

    always_ff @(posedge clk)
    begin
        if (req.we && in_range)
        begin
            mem[req.addr[btfl_pkg::IDX_W-1:0]] <= req.wdata;
        end
        raw_reg <= mem[req.addr[btfl_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        ok_reg <= req.re && in_range;
    end

endmodule
